@@ hw/rtl/ppc_pkg.sv @@
`default_nettype none
package ppc_pkg;

    localparam int unsigned PageSizeW = 17;
    localparam int unsigned MaxPagesW = 7;
    localparam int unsigned ElemsW    = 32;
    localparam int unsigned CfgW      = 32;
    localparam int unsigned HoldW     = 16;
    localparam int unsigned RankW     = 8;

    // cache geometry; counter and rank widths above are sized for these
    localparam int unsigned SlotsPerType = 64;
    localparam int unsigned PageTypes    = 4;
    localparam int unsigned KeyBits      = 20;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_EVICT = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOT_HELD = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    localparam logic [2:0] REG_PAGE_SIZE = 3'd0;
    localparam logic [2:0] REG_MAX_PAGES = 3'd1;
    localparam logic [2:0] REG_ELEMS0    = 3'd2;
    localparam logic [2:0] REG_ELEMS3    = 3'd5;

    // command broadcast along the cell row
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_HIT,      // increment holders of matching slot, dequeue it
        CMD_RELEASE,  // decrement holders of matching slot, queue at rank
        CMD_EVICT,    // drop rank-one unpinned slot of the type
        CMD_ALLOC     // fill first free slot of the type
    } cmd_kind_t;

endpackage
`default_nettype wire

@@ hw/rtl/ppc_cell.sv @@
`default_nettype none
module ppc_cell
    import ppc_pkg::*;
#(
    parameter int unsigned KEY_W  = 20
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_kind_t         cmd,
    input  wire logic [KEY_W-1:0]  cmd_key,
    input  wire logic [RankW-1:0]  cmd_rank,
    input  wire logic              free_in,   // a lower slot of my type is free
    output logic                   free_out,
    output logic                   match,
    output logic                   victim,
    output logic [RankW-1:0]       rank,
    output logic [HoldW-1:0]       holders,
    output logic [KEY_W-1:0]       key
);

    logic              valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [HoldW-1:0]  hold_reg;
    logic [RankW-1:0]  rank_reg;
    logic [RankW-1:0]  ref_rank;

    assign match    = valid_reg && (key_reg == cmd_key);
    assign victim   = valid_reg && (rank_reg == RankW'(1)) && (hold_reg == '0);
    assign rank     = rank_reg;
    assign holders  = hold_reg;
    assign key      = key_reg;
    assign free_out = free_in || !valid_reg;
    // rank of the hit slot being removed from the queue, or the rank to queue a released slot at
    assign ref_rank = cmd_rank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hold_reg  <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            unique case (cmd)
                CMD_CLEAR:
                begin
                    valid_reg <= 1'b0;
                    hold_reg  <= '0;
                    rank_reg  <= '0;
                end
                CMD_HIT:
                begin
                    if (match)
                    begin
                        hold_reg <= hold_reg + 1'b1;
                        rank_reg <= '0;
                    end
                    else if (ref_rank != '0 && rank_reg > ref_rank)
                        rank_reg <= rank_reg - 1'b1;
                end
                CMD_RELEASE:
                begin
                    if (match)
                    begin
                        hold_reg <= hold_reg - 1'b1;
                        if (hold_reg == HoldW'(1) && rank_reg == '0)
                            rank_reg <= ref_rank;
                    end
                end
                CMD_EVICT:
                begin
                    if (victim)
                    begin
                        valid_reg <= 1'b0;
                        hold_reg  <= '0;
                        rank_reg  <= '0;
                    end
                    else if (rank_reg > RankW'(1))
                        rank_reg <= rank_reg - 1'b1;
                end
                CMD_ALLOC:
                begin
                    if (!valid_reg && !free_in)
                    begin
                        valid_reg <= 1'b1;
                        key_reg   <= cmd_key;
                        hold_reg  <= HoldW'(1);
                        rank_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ppc_type_row.sv @@
`default_nettype none
module ppc_type_row
    import ppc_pkg::*;
#(
    parameter int unsigned SLOTS  = 64,
    parameter int unsigned KEY_W  = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_kind_t        cmd,
    input  wire logic [KEY_W-1:0] cmd_key,
    input  wire logic [RankW-1:0] cmd_rank,
    output logic                  found,
    output logic [HoldW-1:0]      found_holders,
    output logic [RankW-1:0]      found_rank,
    output logic                  has_victim,
    output logic [KEY_W-1:0]      victim_key,
    output logic                  has_free,
    output logic [RankW-1:0]      queue_len
);

    logic [SLOTS:0]           free_chain;
    logic [SLOTS-1:0]         m, v;
    logic [HoldW-1:0]         h [SLOTS];
    logic [KEY_W-1:0]         k [SLOTS];
    logic [RankW-1:0]         r [SLOTS];
    logic [RankW-1:0]         qlen_reg;

    assign free_chain[0] = 1'b0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        ppc_cell #(.KEY_W(KEY_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .cmd_key  (cmd_key),
            .cmd_rank (cmd_rank),
            .free_in  (free_chain[i]),
            .free_out (free_chain[i+1]),
            .match    (m[i]),
            .victim   (v[i]),
            .rank     (r[i]),
            .holders  (h[i]),
            .key      (k[i])
        );
    end

    // keys and queue ranks are unique within a type, so at most one match / victim
    always_comb
    begin
        found_holders = '0;
        victim_key    = '0;
        found_rank    = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (m[i]) found_holders = found_holders | h[i];
            if (m[i]) found_rank = found_rank | r[i];
            if (v[i]) victim_key = victim_key | k[i];
        end
    end

    assign found      = |m;
    assign has_victim = |v;
    assign has_free   = free_chain[SLOTS];

    // number of queued slots, tracked alongside the commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qlen_reg <= '0;
        else
        begin
            unique case (cmd)
                CMD_CLEAR:
                    qlen_reg <= '0;
                CMD_HIT:
                begin
                    if (found_rank != '0)
                        qlen_reg <= qlen_reg - 1'b1;
                end
                CMD_RELEASE:
                begin
                    if (found && found_holders == HoldW'(1) && found_rank == '0)
                        qlen_reg <= qlen_reg + 1'b1;
                end
                CMD_EVICT:
                begin
                    if (has_victim)
                        qlen_reg <= qlen_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign queue_len = qlen_reg;

endmodule
`default_nettype wire

@@ hw/rtl/pinned_page_cache_policy_core.sv @@
// channel | valid    | stall    | payload
// in      | in_valid | in_stall | op, page_type, page_key
// out     | out_valid| out_stall| status .. holders
// An item passes capture with the key times page size product, search and
// update along the cell rows, an allocation step after an acquire that misses,
// then the result register.
// The next item is taken once the result register is free or being taken.
// Reset clears every slot at once; configuration returns to its defaults.
// in_stall is high while an item is in flight or the result waits.
`default_nettype none
module pinned_page_cache_policy_core
    import ppc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [1:0]  page_type,
    input  wire logic [19:0] page_key,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic             hit,
    output logic             load_needed,
    output logic [31:0]      load_start,
    output logic [16:0]      load_count,
    output logic             evicted_valid,
    output logic [19:0]      evicted_key,
    output logic             pinned,
    output logic [15:0]      holders
);

    localparam int unsigned KW = (KeyBits < 20) ? KeyBits : 20;

    typedef enum logic [1:0] { S_IDLE, S_EVAL, S_ALLOC, S_DONE } state_t;

    logic [PageSizeW-1:0] page_size_reg;
    logic [MaxPagesW-1:0] max_pages_reg;
    logic [ElemsW-1:0]    elems_reg [4];

    state_t          state_reg;
    op_t             op_reg;
    logic [1:0]      type_reg;
    logic [KW-1:0]   key_reg;
    logic [31:0]     start_reg;
    logic            start_big_reg;
    logic [16:0]     ps_reg;
    logic [6:0]      count_reg [PageTypes];

    cmd_kind_t       cmd [PageTypes];
    logic [RankW-1:0] cmd_rank;
    logic            found [PageTypes];
    logic [HoldW-1:0] fh [PageTypes];
    logic [RankW-1:0] fr [PageTypes];
    logic            hv [PageTypes];
    logic [KW-1:0]   vk [PageTypes];
    logic            hf [PageTypes];
    logic [RankW-1:0] ql [PageTypes];

    logic [2:0]  status_reg;
    logic        hit_reg, load_reg, ev_reg, out_valid_reg;
    logic [31:0] lstart_reg;
    logic [16:0] lcount_reg;
    logic [19:0] evkey_reg;
    logic [15:0] hold_out_reg;

    for (genvar t = 0; t < PageTypes; t++)
    begin : g_row
        ppc_type_row #(.SLOTS(SlotsPerType), .KEY_W(KW)) u_row (
            .clk (clk), .rst_n (rst_n), .cmd (cmd[t]), .cmd_key (key_reg),
            .cmd_rank (cmd_rank), .found (found[t]), .found_holders (fh[t]),
            .found_rank (fr[t]), .has_victim (hv[t]), .victim_key (vk[t]),
            .has_free (hf[t]), .queue_len (ql[t])
        );
    end

    logic        tv;
    logic [1:0]  ti;
    logic [31:0] el;
    logic [6:0]  lim;
    logic [31:0] rem;
    logic        do_evict;
    logic [HoldW-1:0] sh;

    always_comb
    begin
        tv  = 32'(type_reg) < PageTypes;
        ti  = tv ? type_reg : 2'd0;
        el  = elems_reg[type_reg];
        lim = (max_pages_reg == '0) ? 7'd1 : max_pages_reg;
        if (32'(lim) > SlotsPerType)
            lim = 7'(SlotsPerType);
        rem = el - start_reg;
        sh  = fh[ti];
        do_evict = (count_reg[ti] >= lim);
    end

    // outcome of the search cycle
    logic [2:0]       status_next;
    logic             hit_next;
    logic             ev_next;
    logic [19:0]      evkey_next;
    logic [HoldW-1:0] hold_next;
    logic             miss_next;

    always_comb
    begin
        status_next = ST_OK;
        hit_next    = 1'b0;
        ev_next     = 1'b0;
        evkey_next  = '0;
        hold_next   = '0;
        miss_next   = 1'b0;
        if (op_reg != OP_CLEAR)
        begin
            if (!tv)
                status_next = ST_RANGE;
            else if (op_reg == OP_ACQUIRE)
            begin
                if (start_big_reg || start_reg >= el)
                begin
                    status_next = ST_RANGE;
                    hold_next   = found[ti] ? sh : '0;
                end
                else if (found[ti])
                begin
                    if (sh == '1)
                    begin
                        status_next = ST_OVERFLOW;
                        hold_next   = sh;
                    end
                    else
                    begin
                        hit_next  = 1'b1;
                        hold_next = sh + 1'b1;
                    end
                end
                else
                begin
                    miss_next = 1'b1;
                    if (do_evict)
                    begin
                        if (hv[ti] && ql[ti] != '0)
                        begin
                            ev_next    = 1'b1;
                            evkey_next = 20'(vk[ti]);
                        end
                        else
                            status_next = ST_NO_EVICT;
                    end
                end
            end
            else if (op_reg == OP_RELEASE)
            begin
                if (!found[ti] || sh == '0)
                    status_next = ST_NOT_HELD;
                else
                    hold_next = sh - 1'b1;
            end
            else
                hold_next = found[ti] ? sh : '0;
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        for (int t = 0; t < PageTypes; t++)
            cmd[t] = CMD_NONE;
        cmd_rank = '0;
        if (state_reg == S_EVAL)
        begin
            if (op_reg == OP_CLEAR)
                for (int t = 0; t < PageTypes; t++)
                    cmd[t] = CMD_CLEAR;
            else if (tv && op_reg == OP_ACQUIRE && !start_big_reg && start_reg < el)
            begin
                if (found[ti] && sh != '1)
                begin
                    cmd[ti]  = CMD_HIT;
                    cmd_rank = fr[ti];
                end
                else if (!found[ti] && do_evict && hv[ti] && ql[ti] != '0)
                    cmd[ti] = CMD_EVICT;
            end
            else if (tv && op_reg == OP_RELEASE && found[ti] && sh != '0)
            begin
                cmd[ti]  = CMD_RELEASE;
                cmd_rank = ql[ti] + 1'b1;
            end
        end
        else if (state_reg == S_ALLOC)
        begin
            if (status_reg == ST_OK && hf[ti])
                cmd[ti] = CMD_ALLOC;
        end
    end

    // key times page size, taken with the item
    logic [16:0] ps_in;
    logic [36:0] prod;
    assign ps_in = (page_size_reg == '0) ? 17'd1 :
                   (page_size_reg > 17'd65536) ? 17'd65536 : page_size_reg;
    assign prod  = 37'(page_key[KW-1:0]) * 37'(ps_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            page_size_reg <= 17'd1024;
            max_pages_reg <= 7'd64;
            for (int t = 0; t < 4; t++)
                elems_reg[t] <= '0;
            for (int t = 0; t < PageTypes; t++)
                count_reg[t] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PAGE_SIZE)
                    page_size_reg <= cfg_data[16:0];
                else if (cfg_index == REG_MAX_PAGES)
                    max_pages_reg <= cfg_data[6:0];
                else if (cfg_index >= REG_ELEMS0 && cfg_index <= REG_ELEMS3)
                    elems_reg[2'(cfg_index - REG_ELEMS0)] <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        op_reg        <= op_t'(op);
                        type_reg      <= page_type;
                        key_reg       <= page_key[KW-1:0];
                        ps_reg        <= ps_in;
                        start_reg     <= prod[31:0];
                        start_big_reg <= |prod[36:32];
                        state_reg     <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    status_reg   <= status_next;
                    hit_reg      <= hit_next;
                    load_reg     <= 1'b0;
                    lstart_reg   <= '0;
                    lcount_reg   <= '0;
                    ev_reg       <= ev_next;
                    evkey_reg    <= evkey_next;
                    hold_out_reg <= hold_next;
                    state_reg    <= miss_next ? S_ALLOC : S_DONE;
                    if (op_reg == OP_CLEAR)
                    begin
                        for (int t = 0; t < PageTypes; t++)
                            count_reg[t] <= '0;
                    end
                    else if (ev_next)
                        count_reg[ti] <= count_reg[ti] - 1'b1;
                end
                S_ALLOC:
                begin
                    if (status_reg == ST_OK)
                    begin
                        if (hf[ti])
                        begin
                            load_reg     <= 1'b1;
                            lstart_reg   <= start_reg;
                            lcount_reg   <= (rem < 32'(ps_reg)) ? rem[16:0] : ps_reg;
                            hold_out_reg <= 16'd1;
                            count_reg[ti] <= count_reg[ti] + 1'b1;
                        end
                        else
                            status_reg <= ST_NO_EVICT;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign status        = status_reg;
    assign hit           = hit_reg;
    assign load_needed   = load_reg;
    assign load_start    = lstart_reg;
    assign load_count    = lcount_reg;
    assign evicted_valid = ev_reg;
    assign evicted_key   = evkey_reg;
    assign holders       = hold_out_reg;
    assign pinned        = hold_out_reg != '0;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item accepted while busy");
    a_hit_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && load_needed))
        else $error("hit and load together");
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted_valid) |-> (status == ST_OK && load_needed))
        else $error("eviction without load");

endmodule
`default_nettype wire

@@ tb/pinned_page_cache_policy_core_tb.sv @@
`default_nettype none
module pinned_page_cache_policy_core_tb;
    import ppc_pkg::*;

    localparam int NSLOT = 64;
    localparam int NTYPE = 4;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  ptype;
        logic [19:0] key;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic        load_needed;
        logic [31:0] load_start;
        logic [16:0] load_count;
        logic        evicted_valid;
        logic [19:0] evicted_key;
        logic        pinned;
        logic [15:0] holders;
    } resp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [1:0]  page_type;
    logic [19:0] page_key;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic        hit;
    logic        load_needed;
    logic [31:0] load_start;
    logic [16:0] load_count;
    logic        evicted_valid;
    logic [19:0] evicted_key;
    logic        pinned;
    logic [15:0] holders;

    pinned_page_cache_policy_core DUT (.*);

    // cache shadow
    logic [16:0] sh_page_size;
    logic [6:0]  sh_max_pages;
    logic [31:0] sh_elems [NTYPE];
    logic        sh_valid [NTYPE*NSLOT];
    logic [19:0] sh_key [NTYPE*NSLOT];
    int unsigned sh_hold [NTYPE*NSLOT];
    int unsigned sh_rank [NTYPE*NSLOT];
    int unsigned sh_count [NTYPE];

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    req_t  feed[$];
    int    errors = 0;
    int    mismatches = 0;
    int    cycles = 0;
    int    resps_seen = 0;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_off = 0;
    int    pressure_req = 0;
    int    pressure_served = 0;

    function automatic void clear_cache();
        for (int i = 0; i < NTYPE*NSLOT; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_key[i]   = '0;
            sh_hold[i]  = 0;
            sh_rank[i]  = 0;
        end
        for (int t = 0; t < NTYPE; t++)
            sh_count[t] = 0;
    endfunction

    function automatic int lookup(int t, logic [19:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (sh_valid[t*NSLOT+i] && sh_key[t*NSLOT+i] == k)
                return t*NSLOT + i;
        return -1;
    endfunction

    function automatic int released_count(int t);
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++)
            if (sh_valid[t*NSLOT+i] && sh_rank[t*NSLOT+i] != 0)
                n++;
        return n;
    endfunction

    function automatic void unqueue(int t, int s);
        int unsigned r;
        r = sh_rank[s];
        if (r == 0)
            return;
        for (int i = 0; i < NSLOT; i++)
            if (sh_rank[t*NSLOT+i] > r)
                sh_rank[t*NSLOT+i]--;
        sh_rank[s] = 0;
    endfunction

    function automatic resp_t cache_step(req_t rq);
        resp_t rs;
        int t, s, v, f;
        longint unsigned ps, start, elems, lim;
        rs = '0;
        t = int'(rq.ptype);
        if (op_t'(rq.op) == OP_CLEAR)
            clear_cache();
        else if (op_t'(rq.op) == OP_ACQUIRE)
        begin
            ps = sh_page_size == 0 ? 1 : (sh_page_size > 65536 ? 65536 : sh_page_size);
            start = longint'(rq.key) * ps;
            elems = sh_elems[t];
            s = lookup(t, rq.key);
            if (start >= elems)
            begin
                rs.status = ST_RANGE;
                if (s >= 0)
                    rs.holders = 16'(sh_hold[s]);
            end
            else if (s >= 0)
            begin
                if (sh_hold[s] >= 16'hFFFF)
                begin
                    rs.status = ST_OVERFLOW;
                    rs.holders = 16'(sh_hold[s]);
                end
                else
                begin
                    unqueue(t, s);
                    sh_hold[s]++;
                    rs.hit = 1'b1;
                    rs.holders = 16'(sh_hold[s]);
                end
            end
            else
            begin
                lim = sh_max_pages == 0 ? 1 : sh_max_pages;
                if (lim > NSLOT)
                    lim = NSLOT;
                if (sh_count[t] >= lim)
                begin
                    v = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (v < 0 && sh_valid[t*NSLOT+i] && sh_rank[t*NSLOT+i] == 1
                            && sh_hold[t*NSLOT+i] == 0)
                            v = t*NSLOT + i;
                    if (v < 0 || released_count(t) == 0)
                        rs.status = ST_NO_EVICT;
                    else
                    begin
                        rs.evicted_valid = 1'b1;
                        rs.evicted_key = sh_key[v];
                        unqueue(t, v);
                        sh_valid[v] = 1'b0;
                        sh_hold[v] = 0;
                        sh_count[t]--;
                    end
                end
                if (rs.status == ST_OK)
                begin
                    f = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (f < 0 && !sh_valid[t*NSLOT+i])
                            f = t*NSLOT + i;
                    if (f < 0)
                        rs.status = ST_NO_EVICT;
                    else
                    begin
                        sh_valid[f] = 1'b1;
                        sh_key[f] = rq.key;
                        sh_hold[f] = 1;
                        sh_rank[f] = 0;
                        sh_count[t]++;
                        rs.load_needed = 1'b1;
                        rs.load_start = start[31:0];
                        rs.load_count = (elems - start < ps) ? 17'(elems - start) : 17'(ps);
                        rs.holders = 16'd1;
                    end
                end
            end
        end
        else if (op_t'(rq.op) == OP_RELEASE)
        begin
            s = lookup(t, rq.key);
            if (s < 0 || sh_hold[s] == 0)
                rs.status = ST_NOT_HELD;
            else
            begin
                sh_hold[s]--;
                if (sh_hold[s] == 0 && sh_rank[s] == 0)
                    sh_rank[s] = unsigned'(released_count(t) + 1);
                rs.holders = 16'(sh_hold[s]);
            end
        end
        else
        begin
            s = lookup(t, rq.key);
            if (s >= 0)
                rs.holders = 16'(sh_hold[s]);
        end
        rs.pinned = rs.holders != 0;
        return rs;
    endfunction

    initial clk = 0;
    always #10 clk = ~clk;

    logic accepted;
    assign accepted = in_valid && !in_stall;

    always @(posedge clk)
    begin
        if (rst_n && accepted)
            expected_resps = {expected_resps, cache_step(pending_reqs.pop_front())};
    end

    logic taken_last;
    always @(posedge clk)
        taken_last <= rst_n && accepted;

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            resp_t got, want;
            got = {status, hit, load_needed, load_start, load_count,
                   evicted_valid, evicted_key, pinned, holders};
            resps_seen++;
            if (expected_resps.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected item: %p", got);
                mismatches++;
            end
            else
            begin
                want = expected_resps.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: expected %p got %p", want, got);
                    mismatches++;
                end
            end
        end
    end

    // receiver stall; a long hold-off is counted here when requested
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            hold_off  <= 0;
        end
        else if (pressure_req != pressure_served)
        begin
            pressure_served <= pressure_req;
            hold_off  <= 300;
            out_stall <= 1;
        end
        else if (hold_off > 0)
        begin
            out_stall <= 1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            REG_PAGE_SIZE: sh_page_size = val[16:0];
            REG_MAX_PAGES: sh_max_pages = val[6:0];
            default: sh_elems[idx - REG_ELEMS0] = val;
        endcase
    endtask

    task automatic drain();
        while (feed.size() > 0 || in_valid || expected_resps.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // sender process: drives payload from feed; pending_reqs mirrors what is on the port
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 0;
            op        <= '0;
            page_type <= '0;
            page_key  <= '0;
        end
        else if (!in_valid || taken_last)
        begin
            if (feed.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_t r;
                r = feed.pop_front();
                pending_reqs = {pending_reqs, r};
                in_valid <= 1;
                op <= r.op;
                page_type <= r.ptype;
                page_key <= r.key;
            end
            else
                in_valid <= 0;
        end
    end

    function automatic req_t mk(op_t o, int t, logic [19:0] k);
        req_t r;
        r.op = o;
        r.ptype = 2'(t);
        r.key = k;
        return r;
    endfunction

    task automatic random_phase(int n, int sidle, int ridle, bit pressure);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < n; i++)
        begin
            int c;
            int t;
            logic [19:0] k;
            c = $urandom_range(99);
            t = $urandom_range(3);
            k = (c < 90) ? 20'($urandom_range(11)) : 20'($urandom);
            if (c < 45)
                feed = {feed, mk(OP_ACQUIRE, t, k)};
            else if (c < 85)
                feed = {feed, mk(OP_RELEASE, t, k)};
            else if (c < 98)
                feed = {feed, mk(OP_QUERY, t, k)};
            else
                feed = {feed, mk(OP_CLEAR, t, k)};
        end
        if (pressure)
            pressure_req++;
        drain();
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        sh_page_size = 17'd1024;
        sh_max_pages = 7'd64;
        for (int t = 0; t < NTYPE; t++)
            sh_elems[t] = '0;
        clear_cache();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: defaults, elems zero gives a range error on acquire
        feed = {feed, mk(OP_ACQUIRE, 0, 20'd0)};
        feed = {feed, mk(OP_RELEASE, 0, 20'd0)};
        feed = {feed, mk(OP_QUERY, 3, 20'hFFFFF)};
        drain();
        cfg_write(REG_PAGE_SIZE, 32'd0);
        cfg_write(REG_MAX_PAGES, 32'd2);
        cfg_write(REG_ELEMS0, 32'hFFFFFFFF);
        cfg_write(3'(REG_ELEMS0 + 1), 32'd5);
        cfg_write(3'(REG_ELEMS0 + 2), 32'd100);
        cfg_write(REG_ELEMS3, 32'd0);
        feed = {feed, mk(OP_ACQUIRE, 0, 20'hFFFFF)};
        feed = {feed, mk(OP_ACQUIRE, 0, 20'd1)};
        feed = {feed, mk(OP_ACQUIRE, 0, 20'd2)};      // full, nothing released
        feed = {feed, mk(OP_RELEASE, 0, 20'd1)};
        feed = {feed, mk(OP_RELEASE, 0, 20'd1)};      // not held
        feed = {feed, mk(OP_ACQUIRE, 0, 20'd2)};      // evicts key 1
        feed = {feed, mk(OP_QUERY, 0, 20'd2)};
        feed = {feed, mk(OP_QUERY, 0, 20'd7)};
        feed = {feed, mk(OP_ACQUIRE, 1, 20'd5)};      // out of range
        feed = {feed, mk(OP_ACQUIRE, 1, 20'd4)};
        feed = {feed, mk(OP_ACQUIRE, 0, 20'd2)};      // hit
        feed = {feed, mk(OP_CLEAR, 0, 20'd0)};
        feed = {feed, mk(OP_QUERY, 0, 20'd2)};
        drain();
        cfg_write(REG_PAGE_SIZE, 32'h1FFFF);           // clamps to 65536
        cfg_write(REG_MAX_PAGES, 32'd0);
        cfg_write(3'(REG_ELEMS0 + 2), 32'd70000);
        feed = {feed, mk(OP_ACQUIRE, 2, 20'd0)};
        feed = {feed, mk(OP_ACQUIRE, 2, 20'd1)};      // no eviction yet; short last page once key 0 is released
        feed = {feed, mk(OP_RELEASE, 2, 20'd0)};
        feed = {feed, mk(OP_ACQUIRE, 2, 20'd1)};
        drain();

        cfg_write(REG_PAGE_SIZE, 32'd3);
        cfg_write(REG_MAX_PAGES, 32'd4);
        for (int t = 0; t < NTYPE; t++)
            cfg_write(3'(REG_ELEMS0 + t), 32'd30);
        random_phase(400, 10, 69, 1);
        cfg_write(REG_MAX_PAGES, 32'd127);
        cfg_write(REG_PAGE_SIZE, 32'd1);
        for (int t = 0; t < NTYPE; t++)
            cfg_write(3'(REG_ELEMS0 + t), 32'($urandom_range(20)));
        random_phase(450, 69, 10, 0);
        cfg_write(REG_MAX_PAGES, 32'd1);
        cfg_write(REG_ELEMS0, 32'hFFFFFFFF);
        random_phase(450, 0, 0, 0);

        $display("covered %0d result items over acquire, release, query and clear", resps_seen);
        $display("with several page sizes and page limits, including clamped extremes");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
